// ===== rtl/core/sact_pkg.sv =====
// Shared types and constants of the set-associative LRU tag store.
// Used by sact_tag_ram, sact_lookup and set_assoc_lru_cache_tags.
package sact_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_USED  = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [STAMP_W-1:0]    stamp;
  } line_t;

  // One memory row holds a whole set: its access count and every way
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    line_t [MAX_WAYS-1:0]    lines;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             evict;
    logic [WAY_W-1:0] way;
  } lookup_t;

endpackage

// ===== rtl/core/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative tag store with LRU replacement.
// Depends on sact_pkg, sact_tag_ram and sact_lookup.
//
//  port group   | direction | beat content
//  -------------+-----------+------------------------------------------------
//  s_t*         | in        | address[63:0]
//  m_t*         | out       | hit, miss, evict, set_index, way_index, totals
//  p* (APB)     | in / out  | set_bits @0x0, block_bits @0x4, ways_used @0x8
//
//  From acceptance to the result register an address goes through address
//  decode and set read, then way selection, then row write-back with the result.
//  The next address is taken only after the row is written, so one address is
//  in flight at a time and no access ever sees a stale row.
//  Reset clears the row valid bits, totals, set_bits and block_bits, and sets
//  ways_used to 1; no memory sweep is run. A stalled result holds the write-back stage until the result register frees.
module set_assoc_lru_cache_tags (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] address
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [0] hit, [1] miss, [2] evict, [8:3] set_index,
                                  // [11:9] way_index, [43:12] hit_total,
                                  // [75:44] miss_total, [107:76] evict_total,
                                  // [111:108] zero
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sact_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers, stored as written
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_used;

  logic [2:0] sb_eff;
  logic [3:0] ways_eff;

  logic [ADDR_WIDTH-1:0] addr;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [SET_W-1:0]      set_calc;
  logic [SET_W-1:0]      idx_mask;
  logic [6:0]            tag_shift;
  logic [ADDR_WIDTH-1:0] tag_calc;

  row_t    rdata;
  row_t    wdata;
  logic    mem_re;
  logic    mem_we;
  lookup_t look;
  lookup_t decision;

  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;
  logic [CNT_W-1:0] hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt_next;
  logic [CNT_W-1:0] evict_cnt_next;

  logic out_free;
  logic commit;
  logic cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= '0;
      block_bits <= '0;
      ways_used  <= 4'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SET_BITS:   set_bits   <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits <= pwdata[5:0];
        REG_WAYS_USED:  ways_used  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, set_bits};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits};
      REG_WAYS_USED:  prdata = {28'd0, ways_used};
      default:        prdata = '0;
    endcase
  end

  // clamp out-of-range settings
  assign sb_eff   = (set_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits;
  assign ways_eff = (ways_used == 4'd0) ? 4'd1 :
                    (ways_used > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_used;

  // ---------------- control ----------------
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == ST_WRITE) && out_free;

  always_comb begin
    case (state)
      ST_IDLE:  state_next = (s_tvalid && s_tready) ? ST_READ : ST_IDLE;
      ST_READ:  state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_WRITE;
      ST_WRITE: state_next = commit ? ST_IDLE : ST_WRITE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- address decode ----------------
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      addr <= s_tdata;
    end
  end

  assign idx_mask  = SET_W'((7'd1 << sb_eff) - 7'd1);
  assign set_calc  = SET_W'(addr >> block_bits) & idx_mask;
  assign tag_shift = {1'b0, block_bits} + {4'd0, sb_eff};
  // tag is empty once offset and index cover the whole address
  assign tag_calc  = (tag_shift >= 7'(ADDR_WIDTH)) ? '0 : (addr >> tag_shift[5:0]);

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      set_idx <= set_calc;
      tag     <= tag_calc;
    end
  end

  // ---------------- set memory ----------------
  assign mem_re = (state == ST_READ);
  assign mem_we = commit;

  sact_tag_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .raddr (set_calc),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (set_idx),
    .wdata (wdata)
  );

  // ---------------- way selection ----------------
  sact_lookup u_lookup (
    .row    (rdata),
    .tag    (tag),
    .ways   (ways_eff),
    .result (look)
  );

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      decision <= look;
    end
  end

  // ---------------- write-back ----------------
  // rdata holds through ST_WRITE since no new read is issued
  assign count_next = rdata.count + CNT_W'(1);

  always_comb begin
    wdata                          = rdata;
    wdata.count                    = count_next;
    wdata.lines[decision.way].valid = 1'b1;
    wdata.lines[decision.way].tag   = tag;
    wdata.lines[decision.way].stamp = count_next;
  end

  assign hit_cnt_next   = hit_cnt + CNT_W'(decision.hit);
  assign miss_cnt_next  = miss_cnt + CNT_W'(decision.miss);
  assign evict_cnt_next = evict_cnt + CNT_W'(decision.evict);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (commit) begin
      hit_cnt   <= hit_cnt_next;
      miss_cnt  <= miss_cnt_next;
      evict_cnt <= evict_cnt_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {4'd0, evict_cnt_next, miss_cnt_next, hit_cnt_next,
                  decision.way, set_idx, decision.evict, decision.miss, decision.hit};
    end
  end

endmodule

// ===== rtl/core/sact_tag_ram.sv =====
// Set memory of the tag store: one row per set, one read and one write port.
// Depends on sact_pkg. Rows never written read back as all zero.
module sact_tag_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      re,
  input  logic [sact_pkg::SET_W-1:0] raddr,
  output sact_pkg::row_t            rdata,
  input  logic                      we,
  input  logic [sact_pkg::SET_W-1:0] waddr,
  input  sact_pkg::row_t            wdata
);
  import sact_pkg::*;

  row_t                mem [NUM_SETS];
  row_t                rdata_raw;
  logic [NUM_SETS-1:0] row_ok;
  logic                rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_raw <= mem[raddr];
    end
  end

  // Row valid bits stand in for clearing the array after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (we) begin
        row_ok[waddr] <= 1'b1;
      end
      if (re) begin
        rd_ok <= row_ok[raddr];
      end
    end
  end

  assign rdata = rd_ok ? rdata_raw : '0;

endmodule

// ===== rtl/core/sact_lookup.sv =====
// Way selection of one set: first invalid or matching way, else LRU victim.
// Depends on sact_pkg.
module sact_lookup (
  input  sact_pkg::row_t                   row,
  input  logic [sact_pkg::ADDR_WIDTH-1:0]  tag,
  input  logic [3:0]                       ways,
  output sact_pkg::lookup_t                result
);
  import sact_pkg::*;

  logic [MAX_WAYS-1:0] stop;
  logic                found;
  logic [WAY_W-1:0]    first_way;
  logic [WAY_W-1:0]    lru_way;
  logic [STAMP_W-1:0]  lru_stamp;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      stop[w] = (4'(w) < ways) && (!row.lines[w].valid || row.lines[w].tag == tag);
    end
  end

  // Priority pick, lowest way first
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (stop[w]) begin
        found     = 1'b1;
        first_way = WAY_W'(w);
      end
    end
  end

  // Smallest stamp among used ways, ties keep the lower way
  always_comb begin
    lru_way   = '0;
    lru_stamp = row.lines[0].stamp;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (4'(w) < ways && row.lines[w].stamp < lru_stamp) begin
        lru_stamp = row.lines[w].stamp;
        lru_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    result.hit   = found && row.lines[first_way].valid;
    result.miss  = !(found && row.lines[first_way].valid);
    result.evict = !found;
    result.way   = found ? first_way : lru_way;
  end

endmodule

// ===== rtl/core/sact_checker.sv =====
// Port-level checks of the set-associative LRU tag store.
// Depends on set_assoc_lru_cache_tags; attached by the bind at the end.
module sact_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // every lookup is either a hit or a miss
  a_hit_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] ^ m_tdata[1]))
    else $error("hit and miss flags not exclusive");

  // an eviction is always a miss
  a_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("eviction without miss");

  // one address in flight: input closes right after a beat is taken
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second address taken while one is in flight");

endmodule

bind set_assoc_lru_cache_tags sact_checker u_sact_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
